// ===== sv/wrr_pkg.sv =====
// Shared types, widths and tables for the water ripple row remapper.
// Used by wrr_serial_alu and water_ripple_row_remap_top; depends on nothing.
package wrr_pkg;

    localparam int ROW_W   = 10;              // row_index, source_row, horizon
    localparam int HGT_W   = 11;              // screen_height, vertical depth dv
    localparam int CNT_W   = 20;              // frame counter
    localparam int PH_W    = 7;               // phase index 0..99
    localparam int DVD_W   = 22;              // dividend / quotient width
    localparam int MB_W    = 12;              // multiplier / divisor operand width
    localparam int MA_W    = 15;              // multiplicand width
    localparam int PROD_W  = MA_W + MB_W;     // 27-bit product
    localparam int ACC_W   = MA_W + 1;        // high half of the shift-add accumulator
    localparam int ITER_W  = 5;               // iteration counter

    localparam logic [CNT_W-1:0] COUNT_WRAP  = CNT_W'(1000000);
    localparam logic [PH_W-1:0]  PHASE_STEPS = PH_W'(100);

    // Operation codes of the serial arithmetic unit.
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic             frame_start;
    } t_wrr_in;

    typedef struct packed {
        logic [ROW_W-1:0] source_row;
        logic             in_water;
    } t_wrr_out;

    typedef struct packed {
        logic              start;
        logic              op;
        logic [DVD_W-1:0]  opa;      // dividend, or multiplicand in the low bits
        logic [MB_W-1:0]   opb;      // divisor or multiplier
        logic [ITER_W-1:0] nbits;    // iterations to run
    } t_alu_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              bit_vld;  // one quotient bit per divide cycle, MSB first
        logic              qbit;
        logic [PROD_W-1:0] prod;
        logic [DVD_W-1:0]  quo;
    } t_alu_rsp;

    // First quadrant of cos(2*pi*m/100) in Q1.14.
    localparam logic [MA_W-1:0] QUARTER_COS [26] = '{
        15'd16384, 15'd16352, 15'd16255, 15'd16094, 15'd15869, 15'd15582,
        15'd15233, 15'd14825, 15'd14357, 15'd13833, 15'd13255, 15'd12624,
        15'd11943, 15'd11216, 15'd10444, 15'd9630,  15'd8779,  15'd7893,
        15'd6976,  15'd6031,  15'd5063,  15'd4075,  15'd3070,  15'd2053,
        15'd1029,  15'd0
    };

    // Returns {negative, magnitude} of cos(2*pi*m/100) in Q1.14.
    function automatic logic [MA_W:0] cos_q14(input logic [PH_W-1:0] m);
        logic [MA_W-1:0] mag;
        logic            neg;
        mag = '0;
        neg = 1'b0;
        if (m <= PH_W'(25)) begin
            mag = QUARTER_COS[5'(m)];
        end else if (m <= PH_W'(50)) begin
            mag = QUARTER_COS[5'(PH_W'(50) - m)];
            neg = 1'b1;
        end else if (m <= PH_W'(75)) begin
            mag = QUARTER_COS[5'(m - PH_W'(50))];
            neg = 1'b1;
        end else if (m < PHASE_STEPS) begin
            mag = QUARTER_COS[5'(PHASE_STEPS - m)];
        end
        return {neg & (mag != '0), mag};
    endfunction

endpackage

// ===== sv/water_ripple_row_remap_top.sv =====
// Water ripple row remapper: maps a display row to the source row of a rippling reflection.
// Depends on wrr_pkg and wrr_serial_alu.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------------------
//   input    | in        | i_in_valid / o_in_stall    | i_in_data  (row_index, frame_start)
//   output   | out       | o_out_valid / i_out_stall  | o_out_data (source_row, in_water)
//   config   | in/out    | APB psel/penable/pwrite    | horizon_row @0x0, screen_height @0x4
//
// A row above the horizon goes from S_PREP straight to S_DONE. A water row runs the bit-serial
// unit four times: a square, a divide by the water depth, a multiply by the cosine and a
// scaling divide, one bit per cycle, with the sequencer states S_PREP, S_PHASE and S_DONE
// around them.
// One row is in flight at a time; the next transfer is taken as soon as the result sits in
// the output register, even while that register is stalled.
// Reset is synchronous, active low: it clears the frame counter, the state and the output
// valid, and sets horizon_row to 0 and screen_height to 1024.
module water_ripple_row_remap_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  wrr_pkg::t_wrr_in i_in_data,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output wrr_pkg::t_wrr_out o_out_data,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import wrr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_DIV1  = 3'd3;
    localparam logic [2:0] S_PHASE = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_DIV2  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [ITER_W-1:0] MUL_BITS  = ITER_W'(MB_W);
    localparam logic [ITER_W-1:0] DIV1_BITS = ITER_W'(DVD_W);
    localparam logic [ITER_W-1:0] DIV2_BITS = ITER_W'(14);

    // Fold a value below 400 into 0..99.
    function automatic logic [PH_W-1:0] fold100(input logic [8:0] x);
        logic [8:0] y;
        y = x;
        if (y >= 9'd300) begin
            y = y - 9'd300;
        end else if (y >= 9'd200) begin
            y = y - 9'd200;
        end else if (y >= 9'd100) begin
            y = y - 9'd100;
        end
        return y[PH_W-1:0];
    endfunction

    // ---------------------------------------------------------------- configuration
    logic [ROW_W-1:0] r_horizon;
    logic [HGT_W-1:0] r_height;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = paddr[2] ? 32'(r_height) : 32'(r_horizon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon <= '0;
            r_height  <= HGT_W'(1024);
        end else if (w_cfg_wr) begin
            if (paddr[2]) begin
                r_height <= pwdata[HGT_W-1:0];
            end else begin
                r_horizon <= pwdata[ROW_W-1:0];
            end
        end
    end

    // Effective horizon: clamp to the last screen row, zero on an empty screen.
    logic [ROW_W-1:0] w_hz;
    always_comb begin
        if (r_height == '0) begin
            w_hz = '0;
        end else if (HGT_W'(r_horizon) >= r_height) begin
            w_hz = ROW_W'(r_height - HGT_W'(1));
        end else begin
            w_hz = r_horizon;
        end
    end

    // ---------------------------------------------------------------- state
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_frame_cnt;
    logic [PH_W-1:0]  r_cm;          // frame counter mod 100
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_k;
    logic [HGT_W-1:0] r_dv;
    logic [PH_W-1:0]  r_qmod;        // first quotient mod 100, built bit by bit
    logic             r_cneg;
    logic             r_nneg;
    logic [ROW_W-1:0] r_src;
    logic             r_wet;
    logic             r_out_valid;
    t_wrr_out         r_out;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    wrr_serial_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    logic w_in_xfer;
    logic w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------- datapath pieces
    logic [ROW_W-1:0]   w_k;
    logic [HGT_W-1:0]   w_dv;
    logic [HGT_W:0]     w_diff;
    logic [HGT_W-1:0]   w_diff_abs;
    logic [PH_W-1:0]    w_t1, w_t2, w_m;
    logic [MA_W:0]      w_cos;
    logic [MB_W-1:0]    w_kdv;
    logic [29:0]        w_p4, w_bias, w_absn;
    logic               w_nneg;
    logic signed [16:0] w_q, w_d;
    logic [ROW_W-1:0]   w_clamp;

    // Water depth and row offset below the horizon.
    assign w_k        = r_row - w_hz;
    assign w_dv       = (r_height == '0) ? HGT_W'(1) : (r_height - HGT_W'(w_hz));
    assign w_diff     = {1'b0, w_dv} - (HGT_W+1)'(w_k);
    assign w_diff_abs = w_diff[HGT_W] ? HGT_W'(-w_diff) : w_diff[HGT_W-1:0];

    // Phase index m = (4*q1 - 3*count) mod 100.
    assign w_t1  = fold100({r_qmod, 2'b00});
    assign w_t2  = fold100(9'(r_cm) * 9'd3);
    assign w_m   = (w_t1 >= w_t2) ? (w_t1 - w_t2) : (w_t1 + PHASE_STEPS - w_t2);
    assign w_cos = cos_q14(w_m);
    assign w_kdv = MB_W'(r_k) + MB_W'(r_dv);

    // Numerator C*4*(k+dv) + dv*8192 as sign and magnitude.
    assign w_p4   = {1'b0, w_rsp.prod, 2'b00};
    assign w_bias = 30'({r_dv, 13'b0});
    always_comb begin
        if (!r_cneg) begin
            w_absn = w_p4 + w_bias;
            w_nneg = 1'b0;
        end else if (w_p4 >= w_bias) begin
            w_absn = w_p4 - w_bias;
            w_nneg = (w_p4 != w_bias);
        end else begin
            w_absn = w_bias - w_p4;
            w_nneg = 1'b0;
        end
    end

    // Offset, shift up by the horizon and clamp into the rows above the water.
    assign w_q = r_nneg ? -$signed(17'(w_rsp.quo[13:0])) : $signed(17'(w_rsp.quo[13:0]));
    assign w_d = w_q + $signed(17'(w_hz)) - $signed(17'(r_k)) - 17'sd10;
    always_comb begin
        if (w_hz == '0) begin
            w_clamp = '0;
        end else if (w_d >= $signed(17'(w_hz))) begin
            w_clamp = w_hz - ROW_W'(1);
        end else if (w_d < 17'sd0) begin
            w_clamp = '0;
        end else begin
            w_clamp = w_d[ROW_W-1:0];
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state     = r_state;
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_req.opa   = '0;
        w_req.opb   = '0;
        w_req.nbits = MUL_BITS;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_row < w_hz) begin
                    n_state = S_DONE;
                end else begin
                    // square |dv - k|
                    w_req.start = 1'b1;
                    w_req.opa   = DVD_W'(w_diff_abs);
                    w_req.opb   = MB_W'(w_diff_abs);
                    n_state     = S_MUL1;
                end
            end
            S_MUL1: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.op    = OP_DIV;
                    w_req.opa   = w_rsp.prod[DVD_W-1:0];
                    w_req.opb   = MB_W'(r_dv);
                    w_req.nbits = DIV1_BITS;
                    n_state     = S_DIV1;
                end
            end
            S_DIV1: begin
                if (w_rsp.done) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: begin
                w_req.start = 1'b1;
                w_req.opa   = DVD_W'(w_cos[MA_W-1:0]);
                w_req.opb   = w_kdv;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                if (w_rsp.done) begin
                    // |num| / (dv << 14) = (|num| >> 14) / dv
                    w_req.start = 1'b1;
                    w_req.op    = OP_DIV;
                    w_req.opa   = {w_absn[27:14], 8'b0};
                    w_req.opb   = MB_W'(r_dv);
                    w_req.nbits = DIV2_BITS;
                    n_state     = S_DIV2;
                end
            end
            S_DIV2: begin
                if (w_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame_cnt <= '0;
            r_cm        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the frame counter before this row is worked on
            if (w_in_xfer && i_in_data.frame_start) begin
                if (r_frame_cnt == COUNT_WRAP) begin
                    r_frame_cnt <= '0;
                    r_cm        <= '0;
                end else begin
                    r_frame_cnt <= r_frame_cnt + CNT_W'(1);
                    r_cm        <= (r_cm == PHASE_STEPS - PH_W'(1)) ? '0 : r_cm + PH_W'(1);
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_row <= i_in_data.row_index;
        end
        if (r_state == S_PREP) begin
            r_k   <= w_k;
            r_dv  <= w_dv;
            r_wet <= (r_row >= w_hz);
            r_src <= r_row;
        end
        // fold each quotient bit into the running remainder mod 100
        if (r_state == S_MUL1) begin
            r_qmod <= '0;
        end else if (r_state == S_DIV1 && w_rsp.bit_vld) begin
            r_qmod <= fold100({1'b0, r_qmod, w_rsp.qbit});
        end
        if (r_state == S_PHASE) begin
            r_cneg <= w_cos[MA_W];
        end
        if (r_state == S_MUL2 && w_rsp.done) begin
            r_nneg <= w_nneg;
        end
        if (r_state == S_DIV2 && w_rsp.done) begin
            r_src <= w_clamp;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out.source_row <= r_src;
            r_out.in_water   <= r_wet;
        end
    end

    // ---------------------------------------------------------------- checks
    a_alu_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_rsp.busy)
        else $error("arithmetic unit busy while no row is in flight");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_cnt <= COUNT_WRAP) && (r_cm < PHASE_STEPS))
        else $error("frame counter out of range");

    a_cm_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_cnt == '0) |-> (r_cm == '0))
        else $error("phase counter lost track of frame counter");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without a finished row");

endmodule

// ===== sv/wrr_serial_alu.sv =====
// Bit-serial arithmetic unit: shift-add multiply and restoring divide, one bit a cycle.
// Depends on wrr_pkg (request/response structs, operation codes, widths).
module wrr_serial_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrr_pkg::t_alu_req i_req,
    output wrr_pkg::t_alu_rsp o_rsp
);
    import wrr_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_op;
    logic [ITER_W-1:0] r_cnt;
    logic [ACC_W-1:0]  r_hi;     // accumulator high half, or partial remainder
    logic [DVD_W-1:0]  r_lo;     // multiplier / product low bits, or dividend / quotient
    logic [MA_W-1:0]   r_a;
    logic [MB_W-1:0]   r_b;

    logic [ACC_W-1:0]  w_sum;
    logic [MB_W-1:0]   w_trial;
    logic              w_ge;
    logic [MB_W-1:0]   w_rem;

    // Multiply: add multiplicand when the low multiplier bit is set, then shift right.
    assign w_sum   = r_hi + (r_lo[0] ? {1'b0, r_a} : ACC_W'(0));
    // Divide: bring down one dividend bit and try to subtract the divisor.
    assign w_trial = {r_hi[MB_W-2:0], r_lo[DVD_W-1]};
    assign w_ge    = (w_trial >= r_b);
    assign w_rem   = w_ge ? (w_trial - r_b) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= i_req.nbits;
            r_hi  <= '0;
            r_lo  <= (i_req.op == OP_MUL) ? DVD_W'(i_req.opb) : i_req.opa;
            r_a   <= i_req.opa[MA_W-1:0];
            r_b   <= i_req.opb;
        end else if (r_busy) begin
            r_cnt <= r_cnt - ITER_W'(1);
            if (r_op == OP_MUL) begin
                r_hi <= {1'b0, w_sum[ACC_W-1:1]};
                r_lo <= {w_sum[0], r_lo[DVD_W-1:1]};
            end else begin
                r_hi <= ACC_W'(w_rem);
                r_lo <= {r_lo[DVD_W-2:0], w_ge};
            end
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.bit_vld = r_busy && (r_op == OP_DIV);
    assign o_rsp.qbit    = w_ge;
    assign o_rsp.prod    = {r_hi[MA_W-1:0], r_lo[DVD_W-1:DVD_W-MB_W]};
    assign o_rsp.quo     = r_lo;

endmodule
